[rtl/hbs_pkg.sv]
// Shared constants, register indexes, mode codes and a floor helper for the heightmap sampler.
package hbs_pkg;

    localparam int DEFAULT_MAX_COLS = 256;
    localparam int DEFAULT_MAX_ROWS = 256;
    localparam int GRID_AW          = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXAGGERATION = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_LOADED  = 3'd7;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // floor(p / 65536) of a signed product: an arithmetic shift floors
    function automatic logic signed [63:0] floor_q16(input logic signed [63:0] p);
        floor_q16 = p >>> 16;
    endfunction

endpackage

[rtl/hbs_locate.sv]
// Two-stage coordinate mapper: offset then multiply by reciprocal, yields cell and fraction.
module hbs_locate
    import hbs_pkg::*;
(
    input  logic                clk,
    input  logic signed [31:0]  coord,
    input  logic [30:0]         half,
    input  logic [31:0]         inv,
    output logic [31:0]         cell_no,
    output logic [15:0]         frac,
    output logic                neg
);

    logic signed [32:0] off_reg;
    logic [31:0]        inv_reg;
    logic [32:0]        off_next;
    logic [63:0]        prod;

    assign off_next = 33'(coord) + 33'($signed({1'b0, half}));

    always_ff @(posedge clk)
    begin
        off_reg <= $signed(off_next);
        inv_reg <= inv;
    end

    // off stays below 2^32 when non-negative; zero reciprocal forces cell 0
    assign prod    = 64'(off_reg[31:0]) * 64'(inv_reg);
    assign neg     = (inv_reg != 32'd0) && off_reg[32];
    assign cell_no = prod[63:32];
    assign frac    = prod[31:16];

endmodule

[rtl/hbs_blend.sv]
// Registered one-axis linear blend: a + floor((b - a) * f / 65536).
module hbs_blend
    import hbs_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic [15:0]        f,
    output logic signed [31:0] y
);

    logic signed [32:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] sum;

    assign diff = 33'(b) - 33'(a);
    assign prod = 64'(diff) * $signed({48'd0, f});
    assign sum  = 64'(a) + floor_q16(prod);

    always_ff @(posedge clk)
    begin
        y <= sum[31:0];
    end

endmodule

[rtl/heightmap_bilinear_sampler.sv]
// Heightmap bilinear sampler top level: grid memory banks, locate, blend and gain pipeline.
// A query gives its result at result_strobe; writes give none.
// Throughput: one item (write or query) per cycle; busy is always low.
// The grid is held in four full copies, one read port each, so the four neighbors read at
// once; writes are delayed through registers to reach the copies at the read stage, to keep item order.
// Reset clears config (reciprocals: 65536) and valid bits; grid is undefined until written.
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_COLS = DEFAULT_MAX_COLS,
    parameter int MAX_ROWS = DEFAULT_MAX_ROWS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   mode,
    input  logic [15:0]            cell_index,
    input  logic signed [31:0]     sample_value,
    input  logic signed [31:0]     query_x,
    input  logic signed [31:0]     query_z,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   result_strobe,
    output logic signed [31:0]     elevation,
    output logic                   in_bounds
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int NS = 8;

    logic [8:0]          cols_cfg_reg, rows_cfg_reg;
    logic [30:0]         half_w_reg, half_h_reg;
    logic [31:0]         inv_x_reg, inv_z_reg;
    logic signed [31:0]  exag_reg;
    logic                loaded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= '0;
            rows_cfg_reg <= '0;
            half_w_reg   <= '0;
            half_h_reg   <= '0;
            inv_x_reg    <= 32'd65536;
            inv_z_reg    <= 32'd65536;
            exag_reg     <= '0;
            loaded_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_COLS:    cols_cfg_reg <= cfg_data[8:0];
                REG_GRID_ROWS:    rows_cfg_reg <= cfg_data[8:0];
                REG_HALF_WIDTH:   half_w_reg   <= cfg_data[30:0];
                REG_HALF_HEIGHT:  half_h_reg   <= cfg_data[30:0];
                REG_INV_CELL_X:   inv_x_reg    <= cfg_data;
                REG_INV_CELL_Z:   inv_z_reg    <= cfg_data;
                REG_EXAGGERATION: exag_reg     <= $signed(cfg_data);
                REG_GRID_LOADED:  loaded_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // saturated counts (the 9-bit register may exceed MAX)
    logic [CW-1:0] cols;
    logic [RW-1:0] rows;
    assign cols = (32'(cols_cfg_reg) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_cfg_reg);
    assign rows = (32'(rows_cfg_reg) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_cfg_reg);

    assign busy = 1'b0;

    // valid pipe
    logic [NS-1:0] vld_reg;
    logic          q_in;
    assign q_in = start && (mode == MODE_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NS-2:0], q_in};
    end

    // stage 1-2: locate (off registered inside, product combinational at stage 2)
    logic [31:0] cx, cz;
    logic [15:0] fx, fz;
    logic        negx, negz;

    hbs_locate u_loc_x (.clk(clk), .coord(query_x), .half(half_w_reg), .inv(inv_x_reg),
                        .cell_no(cx), .frac(fx), .neg(negx));
    hbs_locate u_loc_z (.clk(clk), .coord(query_z), .half(half_h_reg), .inv(inv_z_reg),
                        .cell_no(cz), .frac(fz), .neg(negz));

    // stage 2 register: bounds check, cell numbers and fractions
    logic        ok2_reg;
    logic [31:0] cx2_reg, cz2_reg;
    logic [15:0] fx2_reg, fz2_reg;
    logic        ok2_next;

    assign ok2_next = loaded_reg && (32'(cols) >= 32'd2) && (32'(rows) >= 32'd2)
                      && !negx && !negz
                      && (cx < 32'(cols) - 32'd1) && (cz < 32'(rows) - 32'd1);

    always_ff @(posedge clk)
    begin
        ok2_reg <= ok2_next;
        cx2_reg <= cx;
        cz2_reg <= cz;
        fx2_reg <= fx;
        fz2_reg <= fz;
    end

    // stage 3: base address = cx + cz * cols (modulo 2^16)
    logic [15:0] base3_reg, cols3_reg;
    logic        ok3_reg;
    logic [15:0] fx3_reg, fz3_reg;
    logic [31:0] base_full;

    assign base_full = cx2_reg + cz2_reg * 32'(cols);

    always_ff @(posedge clk)
    begin
        base3_reg <= base_full[15:0];
        cols3_reg <= 16'(cols);
        ok3_reg   <= ok2_reg;
        fx3_reg   <= fx2_reg;
        fz3_reg   <= fz2_reg;
    end

    // four neighbor addresses; one port per copy of the grid
    logic [GRID_AW-1:0] ra [4];
    assign ra[0] = base3_reg;
    assign ra[1] = base3_reg + 16'd1;
    assign ra[2] = base3_reg + cols3_reg;
    assign ra[3] = base3_reg + cols3_reg + 16'd1;

    logic                 wr_en;
    assign wr_en = start && (mode == MODE_WRITE);

    // delay writes to the read stage so a query never sees a later write
    logic [2:0]           wr_vld_reg;
    logic [GRID_AW-1:0]   wr_addr_reg [3];
    logic signed [31:0]   wr_data_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_vld_reg <= '0;
        else
            wr_vld_reg <= {wr_vld_reg[1:0], wr_en};
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg[0] <= cell_index;
        wr_addr_reg[1] <= wr_addr_reg[0];
        wr_addr_reg[2] <= wr_addr_reg[1];
        wr_data_reg[0] <= sample_value;
        wr_data_reg[1] <= wr_data_reg[0];
        wr_data_reg[2] <= wr_data_reg[1];
    end

    logic signed [31:0] s4_reg [4];
    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic signed [31:0] mem [2**GRID_AW];
        always_ff @(posedge clk)
        begin
            if (wr_vld_reg[2])
                mem[wr_addr_reg[2]] <= wr_data_reg[2];
            s4_reg[g] <= mem[ra[g]];
        end
    end

    // stage 4 side data
    logic        ok4_reg;
    logic [15:0] fx4_reg, fz4_reg;
    always_ff @(posedge clk)
    begin
        ok4_reg <= ok3_reg;
        fx4_reg <= fx3_reg;
        fz4_reg <= fz3_reg;
    end

    // stage 5: horizontal blends
    logic signed [31:0] e0, e1;
    hbs_blend u_b0 (.clk(clk), .a(s4_reg[0]), .b(s4_reg[1]), .f(fx4_reg), .y(e0));
    hbs_blend u_b1 (.clk(clk), .a(s4_reg[2]), .b(s4_reg[3]), .f(fx4_reg), .y(e1));

    logic        ok5_reg;
    logic [15:0] fz5_reg;
    always_ff @(posedge clk)
    begin
        ok5_reg <= ok4_reg;
        fz5_reg <= fz4_reg;
    end

    // stage 6: vertical blend
    logic signed [31:0] elev6;
    hbs_blend u_b2 (.clk(clk), .a(e0), .b(e1), .f(fz5_reg), .y(elev6));

    logic ok6_reg;
    always_ff @(posedge clk)
    begin
        ok6_reg <= ok5_reg;
    end

    // stage 7: gain product
    logic signed [63:0] gain7_reg;
    logic               ok7_reg;
    always_ff @(posedge clk)
    begin
        gain7_reg <= 64'(elev6) * 64'(exag_reg);
        ok7_reg   <= ok6_reg;
    end

    // stage 8: floor, saturate, output register
    logic signed [63:0] scaled;
    logic signed [31:0] sat;
    assign scaled = floor_q16(gain7_reg);

    always_comb
    begin
        if (scaled > 64'sd2147483647)
            sat = 32'sh7FFFFFFF;
        else if (scaled < -64'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = scaled[31:0];
    end

    logic signed [31:0] elev_reg;
    logic               inb_reg;
    always_ff @(posedge clk)
    begin
        elev_reg <= ok7_reg ? sat : 32'sd0;
        inb_reg  <= ok7_reg;
    end

    assign result_strobe = vld_reg[NS-1];
    assign elevation     = elev_reg;
    assign in_bounds     = inb_reg;

endmodule

[rtl/hbs_checker.sv]
// Port-level checker for the heightmap sampler, bound to the top level.
module hbs_checker
    import hbs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               mode,
    input logic               result_strobe,
    input logic signed [31:0] elevation,
    input logic               in_bounds
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !in_bounds) |-> (elevation == 32'sd0))
        else $error("out-of-bounds result not zero");

    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && mode == MODE_QUERY, 8))
        else $error("result without query");

    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_QUERY) |-> ##8 result_strobe)
        else $error("query lost");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
    .result_strobe(result_strobe), .elevation(elevation), .in_bounds(in_bounds)
);
